// ----- design/rgbe_pkg.sv -----
// Shared types, constants and helpers for the RGBE encoder.
package rgbe_pkg;
    localparam logic [7:0]  ExpAllOnes = 8'hFF;
    // Bit pattern of single-precision 1e-32.
    localparam logic [31:0] TinyBits   = 32'h0A4FB11F;
    localparam logic [7:0]  ExpBias    = 8'd2;

    typedef struct packed {
        logic        any_inf;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
    } t_clean;

    // Map a float pattern to an unsigned key whose order matches float order.
    function automatic logic [31:0] order_key(input logic [31:0] b);
        order_key = b[31] ? ~b : {1'b1, b[30:0]};
    endfunction
endpackage

// ----- design/rgbe_clean.sv -----
// Stage 1: NaN squash and infinity detect.
module rgbe_clean (
    input  logic                i_clk,
    input  logic                i_adv,
    input  logic [31:0]         i_red,
    input  logic [31:0]         i_green,
    input  logic [31:0]         i_blue,
    output rgbe_pkg::t_clean    o_clean
);
    function automatic logic [31:0] squash(input logic [31:0] b);
        squash = (b[30:23] == rgbe_pkg::ExpAllOnes && b[22:0] != '0) ? '0 : b;
    endfunction
    function automatic logic is_inf(input logic [31:0] b);
        is_inf = (b[30:23] == rgbe_pkg::ExpAllOnes && b[22:0] == '0);
    endfunction

    rgbe_pkg::t_clean r_clean;
    rgbe_pkg::t_clean n_clean;

    always_comb begin
        n_clean.red     = squash(i_red);
        n_clean.green   = squash(i_green);
        n_clean.blue    = squash(i_blue);
        n_clean.any_inf = is_inf(i_red) || is_inf(i_green) || is_inf(i_blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_clean <= n_clean;
        end
    end

    assign o_clean = r_clean;
endmodule

// ----- design/rgbe_scale.sv -----
// Shift one component down to its mantissa byte for a given max exponent.
module rgbe_scale (
    input  logic [31:0] i_comp,
    input  logic [7:0]  i_vexp,
    output logic [7:0]  o_byte
);
    logic [7:0]  ce;
    logic [23:0] sig;
    logic [8:0]  sh;
    logic [23:0] shifted;

    always_comb begin
        ce      = (i_comp[30:23] == '0) ? 8'd1 : i_comp[30:23];
        sig     = {(i_comp[30:23] != '0), i_comp[22:0]};
        sh      = {1'b0, i_vexp} - {1'b0, ce} + 9'd16;
        shifted = sig >> sh[4:0];
        if (i_comp[31] || sh[8] || sh >= 9'd32) begin
            o_byte = '0;
        end else if (ce > i_vexp) begin
            o_byte = 8'hFF;
        end else begin
            o_byte = shifted[7:0];
        end
    end
endmodule

// ----- design/rgb_float_to_rgbe_encoder.sv -----
// Top level of the RGBE shared-exponent encoder pipeline.
//
// One request in carries three single-precision bit patterns (red, green,
// blue); one request out carries four RGBE bytes. Both channels use
// valid/stall: a request moves on an edge where valid is high and stall low.
//
// Pipeline, three register stages, throughput one pixel per cycle while
// the output is not stalled:
//   stage 1: drop NaNs to zero, flag infinities
//   stage 2: pick the signed maximum through order-preserving keys,
//            compare it against 1e-32 and the exponent overflow limit
//   stage 3: shift each component into its mantissa byte (output register)
// Each stage holds a valid bit that travels with its data. The whole
// pipeline advances when the output register is empty or being taken, so a
// downstream stall freezes every stage and nothing is lost or repeated;
// o_stall goes high in every cycle where a waiting output result is stalled,
// even when the earlier stages are empty.
// Reset clears all valid bits; payload registers are not reset.
module rgb_float_to_rgbe_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_red_bits,
    input  logic [31:0] i_green_bits,
    input  logic [31:0] i_blue_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_mantissa,
    output logic [7:0]  o_green_mantissa,
    output logic [7:0]  o_blue_mantissa,
    output logic [7:0]  o_shared_exponent
);
    logic [2:0] r_vld;
    logic       adv;

    // Advance everything unless the output holds an untaken result.
    assign adv     = !(r_vld[2] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // Stage 1.
    rgbe_pkg::t_clean s1;
    rgbe_clean u_clean (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_red  (i_red_bits),
        .i_green(i_green_bits),
        .i_blue (i_blue_bits),
        .o_clean(s1)
    );

    // Stage 2: maximum and classification.
    logic [31:0] k_r, k_g, k_b, n_max;
    logic [31:0] r_red, r_grn, r_blu;
    logic [7:0]  r_vexp;
    logic        r_sat, r_zero;

    always_comb begin
        k_r = rgbe_pkg::order_key(s1.red);
        k_g = rgbe_pkg::order_key(s1.green);
        k_b = rgbe_pkg::order_key(s1.blue);
        n_max = s1.red;
        if (k_g > k_r) begin
            n_max = s1.green;
        end
        if (k_b > rgbe_pkg::order_key(n_max)) begin
            n_max = s1.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_red  <= s1.red;
            r_grn  <= s1.green;
            r_blu  <= s1.blue;
            r_vexp <= n_max[30:23];
            r_zero <= !s1.any_inf && (rgbe_pkg::order_key(n_max)
                      < rgbe_pkg::order_key(rgbe_pkg::TinyBits));
            r_sat  <= s1.any_inf || (n_max[31] == 1'b0 && n_max[30:23] >= 8'd254);
        end
    end

    // Stage 3: mantissa bytes into the output register.
    logic [7:0] b_r, b_g, b_b;
    rgbe_scale u_sr (.i_comp(r_red), .i_vexp(r_vexp), .o_byte(b_r));
    rgbe_scale u_sg (.i_comp(r_grn), .i_vexp(r_vexp), .o_byte(b_g));
    rgbe_scale u_sb (.i_comp(r_blu), .i_vexp(r_vexp), .o_byte(b_b));

    logic [7:0] r_or, r_og, r_ob, r_oe;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_sat) begin
                r_or <= 8'hFF; r_og <= 8'hFF; r_ob <= 8'hFF; r_oe <= 8'hFF;
            end else if (r_zero) begin
                r_or <= '0; r_og <= '0; r_ob <= '0; r_oe <= '0;
            end else begin
                r_or <= b_r; r_og <= b_g; r_ob <= b_b;
                r_oe <= r_vexp + rgbe_pkg::ExpBias;
            end
        end
    end

    assign o_red_mantissa    = r_or;
    assign o_green_mantissa  = r_og;
    assign o_blue_mantissa   = r_ob;
    assign o_shared_exponent = r_oe;
endmodule
